@@ hdl/sbfr_pkg.sv @@
// shared types, constants and the crc step for the stuffed bus frame receiver
`default_nettype none

package sbfr_pkg;

   // configuration register indexes
   localparam logic [2:0] CSR_CRC_POLY     = 3'd0;
   localparam logic [2:0] CSR_ACK_ID_COUNT = 3'd1;
   localparam logic [2:0] CSR_ACK_ID_A     = 3'd2;

   // configuration reset values
   localparam logic [7:0] CRC_POLY_RESET   = 8'h13;

   // frame format constants
   localparam logic [3:0] MAX_PAYLOAD      = 4'd13;
   localparam logic [3:0] LEN_MASK         = 4'hf;
   localparam logic [7:0] END_MARK         = 8'h7e;
   localparam logic [7:0] MASK_FIRST       = 8'h80;
   localparam logic [7:0] MASK_START       = 8'h02;
   localparam logic [4:0] RESP_DONE_MASK   = 5'h1f;
   localparam logic [3:0] STUFF_RUN        = 4'd5;
   localparam logic [3:0] ABORT_RUN        = 4'd7;
   localparam logic [3:0] RUN_SAT          = 4'hf;
   localparam logic [4:0] DEST_ID_POS      = 5'd2;

   // input beat: one sampled bus bit
   typedef struct packed {
      logic tx_busy;
      logic rx_bit;
   } req_type;

   // result beat
   typedef struct packed {
      logic       frame_abort;
      logic       ack_request;
      logic       crc_ok;
      logic       frame_done;
      logic [4:0] byte_position;
      logic [7:0] byte_value;
      logic       byte_valid;
   } rsp_type;

   // one byte through an msb-first crc-8 table entry
   function automatic logic [7:0] crc8_byte(input logic [7:0] x, input logic [7:0] poly);
      logic [7:0] c;
      c = x;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ poly;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

@@ hdl/stuffed_bus_frame_receiver.sv @@
// Stuffed bus frame receiver: one sampled bus bit per req beat, one result per beat.
// req side: req_tdata carries rx_bit and tx_busy for one bit-time tick.
// rsp side: every req beat gives exactly one rsp beat, which reports a finished
//   field byte, its position, crc status, acknowledge request or frame abort;
//   rsp_tlast marks the response field that closes a frame.
// csr side: register writes by index (0 crc polynomial, 1 id count, 2.. ids),
//   always ready; write only while no beat is in flight.
// Path: a taken beat waits in the input register, is decoded from it and
//   is shown on rsp once the result register takes the decoded result.
// Throughput: one beat per cycle; the input register and the result register
//   both move every cycle while rsp_tready is high.
// Stall: with rsp_tready low the result register holds and the input register
//   takes one more beat, then req_tready falls until rsp frees up.
// Reset: synchronous; the receiver goes idle waiting for a start bit, the
//   polynomial returns to 0x13 and all ids to zero, both registers empty.
`default_nettype none

module stuffed_bus_frame_receiver
   import sbfr_pkg::*;
#(
   parameter int ACK_IDS = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // rx_bit, tx_busy, zero fill
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // byte_valid, byte_value, byte_position,
                                         // crc_ok, ack_request, frame_abort, zero fill
   output logic             rsp_tlast,   // frame_done
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [7:0]  csr_wdata
);

   logic                    req_valid_ff;
   req_type                 req_data_ff;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_data_ff;
   logic                    advance;
   rsp_type                 core_rsp;
   logic [7:0]              crc_poly;
   logic [2:0]              ack_id_count;
   logic [ACK_IDS-1:0][7:0] ack_ids;

   // configuration registers
   sbfr_csr #(
      .ACK_IDS (ACK_IDS)
   ) u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .crc_poly     (crc_poly),
      .ack_id_count (ack_id_count),
      .ack_ids      (ack_ids)
   );

   assign csr_ready = 1'b1;

   // pipeline moves when the result register is free or being drained
   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_tready) begin
         req_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         req_data_ff <= {req_tdata[1], req_tdata[0]};
      end
   end

   // frame decoder
   sbfr_rx_core #(
      .ACK_IDS (ACK_IDS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .req          (req_data_ff),
      .crc_poly     (crc_poly),
      .ack_id_count (ack_id_count),
      .ack_ids      (ack_ids),
      .rsp          (core_rsp)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= core_rsp;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_data_ff.frame_done;
   assign rsp_tdata  = {7'd0,
                        rsp_data_ff.frame_abort,
                        rsp_data_ff.ack_request,
                        rsp_data_ff.crc_ok,
                        rsp_data_ff.byte_position,
                        rsp_data_ff.byte_value,
                        rsp_data_ff.byte_valid};

   // a decoded beat always lands in the result register
   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("decoded beat lost");

   // a waiting input beat is kept until it is decoded
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && !advance |=> req_valid_ff && $stable(req_data_ff))
      else $error("pending input beat dropped");

   // a stalled result beat holds until it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("stalled result beat changed");

endmodule

`default_nettype wire

@@ hdl/sbfr_csr.sv @@
// configuration register file of the stuffed bus frame receiver
`default_nettype none

module sbfr_csr
   import sbfr_pkg::*;
#(
   parameter int ACK_IDS = 4
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_valid,
   input  wire logic [2:0]              csr_index,
   input  wire logic [7:0]              csr_wdata,
   output logic      [7:0]              crc_poly,
   output logic      [2:0]              ack_id_count,
   output logic      [ACK_IDS-1:0][7:0] ack_ids
);

   logic [7:0]              crc_poly_ff;
   logic [2:0]              ack_id_count_ff;
   logic [ACK_IDS-1:0][7:0] ack_ids_ff;

   // register writes, unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         crc_poly_ff     <= CRC_POLY_RESET;
         ack_id_count_ff <= '0;
         ack_ids_ff      <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CRC_POLY: begin
               crc_poly_ff <= csr_wdata;
            end
            CSR_ACK_ID_COUNT: begin
               ack_id_count_ff <= csr_wdata[2:0];
            end
            default: begin
            end
         endcase
         for (int k = 0; k < ACK_IDS; k++) begin
            if (csr_index == 3'(int'(CSR_ACK_ID_A) + k)) begin
               ack_ids_ff[k] <= csr_wdata;
            end
         end
      end
   end

   assign crc_poly     = crc_poly_ff;
   assign ack_id_count = ack_id_count_ff;
   assign ack_ids      = ack_ids_ff;

endmodule

`default_nettype wire

@@ hdl/sbfr_rx_core.sv @@
// frame state and per-bit destuffing, crc and field decode
`default_nettype none

module sbfr_rx_core
   import sbfr_pkg::*;
#(
   parameter int ACK_IDS = 4
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    step,
   input  wire req_type                 req,
   input  wire logic [7:0]              crc_poly,
   input  wire logic [2:0]              ack_id_count,
   input  wire logic [ACK_IDS-1:0][7:0] ack_ids,
   output rsp_type                      rsp
);

   typedef enum logic [2:0] {
      ST_START    = 3'd0,
      ST_LENGTH   = 3'd1,
      ST_PAYLOAD  = 3'd2,
      ST_CRC      = 3'd3,
      ST_END_MARK = 3'd4,
      ST_RESPONSE = 3'd5
   } stage_type;

   logic       listening_ff, listening_in;
   stage_type  stage_ff, stage_in;
   logic [7:0] mask_ff, mask_in;
   logic [7:0] shift_ff, shift_in;
   logic [3:0] ones_ff, ones_in;
   logic [3:0] zeros_ff, zeros_in;
   logic [3:0] left_ff, left_in;
   logic [4:0] count_ff, count_in;
   logic [7:0] crc_ff, crc_in;
   logic [7:0] dest_ff, dest_in;

   logic       go;
   logic       stuffed;
   logic       id_hit;
   logic [3:0] len;
   rsp_type    res;

   // destination id against the enabled ids
   always_comb begin
      id_hit = 1'b0;
      for (int k = 0; k < ACK_IDS; k++) begin
         if (3'(k) < ack_id_count && ack_ids[k] == dest_ff) begin
            id_hit = 1'b1;
         end
      end
   end

   // one bus bit through the frame decoder
   always_comb begin
      listening_in = listening_ff;
      stage_in     = stage_ff;
      mask_in      = mask_ff;
      shift_in     = shift_ff;
      ones_in      = ones_ff;
      zeros_in     = zeros_ff;
      left_in      = left_ff;
      count_in     = count_ff;
      crc_in       = crc_ff;
      dest_in      = dest_ff;
      res          = '0;
      go           = 1'b0;
      stuffed      = 1'b0;
      len          = shift_ff[3:0] & LEN_MASK;

      if (!req.tx_busy) begin
         // frame start or long run check
         if (!listening_ff) begin
            if (req.rx_bit) begin
               listening_in = 1'b1;
               stage_in     = ST_START;
               mask_in      = MASK_START;
               shift_in     = '0;
               ones_in      = '0;
               zeros_in     = '0;
               left_in      = '0;
               count_in     = '0;
               crc_in       = '0;
               dest_in      = '0;
               go           = 1'b1;
            end
         end else if (ones_ff > ABORT_RUN || zeros_ff > ABORT_RUN) begin
            listening_in    = 1'b0;
            stage_in        = ST_START;
            mask_in         = MASK_FIRST;
            shift_in        = '0;
            ones_in         = '0;
            zeros_in        = '0;
            res.frame_abort = 1'b1;
         end else begin
            go = 1'b1;
         end

         if (go) begin
            unique case (stage_in) inside
               ST_START: begin
                  if (req.rx_bit) shift_in = shift_in | mask_in;
                  mask_in = mask_in >> 1;
                  if (mask_in == '0) begin
                     res.byte_valid    = 1'b1;
                     res.byte_value    = {7'd0, shift_in[0]};
                     res.byte_position = count_in;
                     count_in          = count_in + 5'd1;
                     shift_in          = '0;
                     mask_in           = MASK_FIRST;
                     stage_in          = ST_LENGTH;
                  end
               end
               ST_LENGTH, ST_PAYLOAD, ST_CRC: begin
                  // drop the bit after five equal bits
                  stuffed = (ones_in == STUFF_RUN) || (zeros_in == STUFF_RUN);
                  if (!stuffed) begin
                     if (req.rx_bit) shift_in = shift_in | mask_in;
                     mask_in = mask_in >> 1;
                  end
                  if (req.rx_bit) begin
                     if (ones_in < RUN_SAT) ones_in = ones_in + 4'd1;
                     zeros_in = '0;
                  end else begin
                     if (zeros_in < RUN_SAT) zeros_in = zeros_in + 4'd1;
                     ones_in = '0;
                  end
                  if (mask_in == '0) begin
                     crc_in = crc8_byte(shift_in ^ crc_in, crc_poly);
                     len    = shift_in[3:0] & LEN_MASK;
                     if (stage_in == ST_LENGTH && len > MAX_PAYLOAD) begin
                        listening_in    = 1'b0;
                        stage_in        = ST_START;
                        mask_in         = MASK_FIRST;
                        shift_in        = '0;
                        res.frame_abort = 1'b1;
                     end else begin
                        if (stage_in == ST_LENGTH) begin
                           left_in  = len;
                           stage_in = (len != '0) ? ST_PAYLOAD : ST_CRC;
                        end else if (stage_in == ST_PAYLOAD) begin
                           if (count_in == DEST_ID_POS) dest_in = shift_in;
                           if (left_in <= 4'd1) begin
                              left_in  = '0;
                              stage_in = ST_CRC;
                           end else begin
                              left_in = left_in - 4'd1;
                           end
                        end else begin
                           ones_in  = '0;
                           zeros_in = '0;
                           stage_in = ST_END_MARK;
                        end
                        res.byte_valid    = 1'b1;
                        res.byte_value    = shift_in;
                        res.byte_position = count_in;
                        count_in          = count_in + 5'd1;
                        shift_in          = '0;
                        mask_in           = MASK_FIRST;
                     end
                  end
               end
               ST_END_MARK: begin
                  if (req.rx_bit) shift_in = shift_in | mask_in;
                  mask_in = mask_in >> 1;
                  if (mask_in == '0) begin
                     res.crc_ok        = (crc_in == '0);
                     res.ack_request   = (shift_in == END_MARK) && id_hit;
                     res.byte_valid    = 1'b1;
                     res.byte_value    = shift_in;
                     res.byte_position = count_in;
                     count_in          = count_in + 5'd1;
                     shift_in          = '0;
                     mask_in           = MASK_FIRST;
                     stage_in          = ST_RESPONSE;
                  end
               end
               ST_RESPONSE: begin
                  // three response bits land in bits 7..5
                  if (req.rx_bit) shift_in = shift_in | mask_in;
                  mask_in = mask_in >> 1;
                  if (mask_in == '0 || (mask_in[4:0] & RESP_DONE_MASK) != '0) begin
                     res.byte_valid    = 1'b1;
                     res.byte_value    = shift_in;
                     res.byte_position = count_in;
                     res.frame_done    = 1'b1;
                     res.crc_ok        = (crc_in == '0);
                     count_in          = count_in + 5'd1;
                     listening_in      = 1'b0;
                     stage_in          = ST_START;
                     mask_in           = MASK_FIRST;
                     shift_in          = '0;
                  end
               end
               default: begin
                  listening_in = 1'b0;
                  stage_in     = ST_START;
                  mask_in      = MASK_FIRST;
                  shift_in     = '0;
               end
            endcase
         end
      end
   end

   // frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         listening_ff <= 1'b0;
         stage_ff     <= ST_START;
         mask_ff      <= MASK_FIRST;
         shift_ff     <= '0;
         ones_ff      <= '0;
         zeros_ff     <= '0;
         left_ff      <= '0;
         count_ff     <= '0;
         crc_ff       <= '0;
         dest_ff      <= '0;
      end else if (step) begin
         listening_ff <= listening_in;
         stage_ff     <= stage_in;
         mask_ff      <= mask_in;
         shift_ff     <= shift_in;
         ones_ff      <= ones_in;
         zeros_ff     <= zeros_in;
         left_ff      <= left_in;
         count_ff     <= count_in;
         crc_ff       <= crc_in;
         dest_ff      <= dest_in;
      end
   end

   assign rsp = res;

   // a finished or dropped frame leaves the receiver idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      step && res.frame_done |=> !listening_ff)
      else $error("receiver still listening after frame end");

   a_abort_idle: assert property (@(posedge clock) disable iff (reset)
      step && res.frame_abort |=> !listening_ff)
      else $error("receiver still listening after abort");

   // acknowledge only on the end mark byte
   a_ack_stage: assert property (@(posedge clock) disable iff (reset)
      step && res.ack_request |-> stage_ff == ST_END_MARK && res.byte_valid)
      else $error("acknowledge request outside end mark");

   // any byte other than the response keeps the frame live
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      step && res.byte_valid && !res.frame_done |=> listening_ff)
      else $error("byte reported without a live frame");

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// self-checking testbench for the stuffed bus frame receiver: frame stimulus, predictor, checker
module tb_top;
   import sbfr_pkg::*;

   localparam int ID_SLOTS         = 4;
   localparam int STALL_LIMIT      = 2000;
   localparam int DRAIN_TAIL       = 8;
   localparam int LONG_HOLD_AT     = 400;
   localparam int LONG_HOLD_CYCLES = 150;

   // register indexes past the ones the package names
   localparam logic [2:0] CSR_ACK_ID_B = CSR_ACK_ID_A + 3'd1;
   localparam logic [2:0] CSR_ACK_ID_C = CSR_ACK_ID_A + 3'd2;
   localparam logic [2:0] CSR_ACK_ID_D = CSR_ACK_ID_A + 3'd3;
   localparam logic [2:0] CSR_SPARE_LO = 3'd6;
   localparam logic [2:0] CSR_SPARE_HI = 3'd7;

   // payload fill patterns
   localparam int PAT_RANDOM = 0;
   localparam int PAT_ZEROS  = 1;
   localparam int PAT_ONES   = 2;

   typedef enum logic [2:0] {
      ST_START, ST_LENGTH, ST_PAYLOAD, ST_CRC, ST_MARK, ST_RESPONSE
   } frame_stage_type;

   typedef enum {
      FRAME_GOOD, FRAME_BAD_CRC, FRAME_BAD_MARK, FRAME_OVERLEN, FRAME_NO_STUFF, FRAME_CUT
   } frame_kind_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // rx_bit, tx_busy, zero fill
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;           // byte_valid, byte_value, byte_position,
                                     // crc_ok, ack_request, frame_abort, zero fill
   logic        rsp_tlast;           // frame_done
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = 3'd0;
   logic [7:0]  csr_wdata = 8'h00;

   stuffed_bus_frame_receiver #(.ACK_IDS(ID_SLOTS)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // bus ticks waiting to be sent and expected result beats
   req_type pending_ticks[$];
   rsp_type expected_beats[$];

   int  pushed_total = 0;
   int  results_seen = 0;
   int  ticks_accepted = 0;
   int  errors = 0;
   int  frames_closed = 0;
   int  frames_dropped = 0;
   int  acks_seen = 0;
   int  crc_good = 0;
   int  phases_run = 0;
   int  idle_cycles = 0;
   bit  bursty = 1'b1;
   bit  req_beat_taken = 1'b0;
   int  send_gap = 0;
   int  sink_gap = 0;
   int  hold_left = 0;
   bit  long_hold_done = 1'b0;

   // predictor copy of the registers
   logic [7:0] cfg_poly = CRC_POLY_RESET;
   logic [2:0] cfg_id_count = 3'd0;
   logic [7:0] cfg_ids [ID_SLOTS] = '{default: 8'h00};

   // predictor copy of the receiver state
   logic            rx_active = 1'b0;
   frame_stage_type rx_stage = ST_START;
   logic [7:0]      rx_mask = MASK_FIRST;
   logic [7:0]      rx_shift = 8'h00;
   logic [3:0]      run_ones = 4'd0;
   logic [3:0]      run_zeros = 4'd0;
   logic [3:0]      left_cnt = 4'd0;
   logic [4:0]      pos_cnt = 5'd0;
   logic [7:0]      crc_run = 8'h00;
   logic [7:0]      dest_byte = 8'h00;

   // stuffing encoder state for the generator
   logic enc_level = 1'b0;
   int   enc_run = 0;
   int   cut_budget = -1;

   // msb-first crc-8 over one byte with the current polynomial
   function automatic logic [7:0] crc_advance(input logic [7:0] v);
      logic [7:0] c;
      c = v;
      repeat (8) c = c[7] ? ((c << 1) ^ cfg_poly) : (c << 1);
      return c;
   endfunction

   function automatic logic id_listed();
      int n;
      n = (cfg_id_count > ID_SLOTS) ? ID_SLOTS : cfg_id_count;
      for (int k = 0; k < n; k++) begin
         if (cfg_ids[k] == dest_byte) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic string rsp_text(input rsp_type r);
      return $sformatf("valid=%b byte=%h pos=%0d done=%b crc_ok=%b ack=%b abort=%b",
                       r.byte_valid, r.byte_value, r.byte_position, r.frame_done,
                       r.crc_ok, r.ack_request, r.frame_abort);
   endfunction

   task automatic apply_register(input logic [2:0] idx, input logic [7:0] val);
      unique case (idx)
         CSR_CRC_POLY:     cfg_poly = val;
         CSR_ACK_ID_COUNT: cfg_id_count = val[2:0];
         CSR_ACK_ID_A:     cfg_ids[0] = val;
         CSR_ACK_ID_B:     cfg_ids[1] = val;
         CSR_ACK_ID_C:     cfg_ids[2] = val;
         CSR_ACK_ID_D:     cfg_ids[3] = val;
         default: ;
      endcase
   endtask

   task automatic drop_frame();
      rx_active = 1'b0;
      rx_stage = ST_START;
      rx_mask = MASK_FIRST;
      rx_shift = 8'h00;
   endtask

   // report a finished field byte and step to the next position
   task automatic close_field(input logic [7:0] v, inout rsp_type r);
      r.byte_valid = 1'b1;
      r.byte_value = v;
      r.byte_position = pos_cnt;
      pos_cnt = pos_cnt + 5'd1;
      rx_shift = 8'h00;
      rx_mask = MASK_FIRST;
   endtask

   // expected result of one bus tick
   task automatic predict_tick(input req_type t, output rsp_type r);
      logic [3:0] len_nib;
      logic       stuffed;
      r = '0;
      if (t.tx_busy) return;
      if (!rx_active) begin
         if (!t.rx_bit) return;
         rx_active = 1'b1;
         rx_stage = ST_START;
         rx_mask = MASK_START;
         rx_shift = 8'h00;
         run_ones = 4'd0;
         run_zeros = 4'd0;
         left_cnt = 4'd0;
         pos_cnt = 5'd0;
         crc_run = 8'h00;
         dest_byte = 8'h00;
      end else if (run_ones > ABORT_RUN || run_zeros > ABORT_RUN) begin
         // long run of equal bits kills the frame, the bit is lost
         drop_frame();
         run_ones = 4'd0;
         run_zeros = 4'd0;
         r.frame_abort = 1'b1;
         return;
      end
      case (rx_stage) inside
         ST_START: begin
            if (t.rx_bit) rx_shift |= rx_mask;
            rx_mask >>= 1;
            if (rx_mask == 8'h00) begin
               close_field({7'b0, rx_shift[0]}, r);
               rx_stage = ST_LENGTH;
            end
         end
         ST_LENGTH, ST_PAYLOAD, ST_CRC: begin
            // a tick after five equal bits is a stuff bit, counted but not stored
            stuffed = (run_ones == STUFF_RUN) || (run_zeros == STUFF_RUN);
            if (!stuffed) begin
               if (t.rx_bit) rx_shift |= rx_mask;
               rx_mask >>= 1;
            end
            if (t.rx_bit) begin
               if (run_ones != RUN_SAT) run_ones = run_ones + 4'd1;
               run_zeros = 4'd0;
            end else begin
               if (run_zeros != RUN_SAT) run_zeros = run_zeros + 4'd1;
               run_ones = 4'd0;
            end
            if (rx_mask == 8'h00) begin
               crc_run = crc_advance(rx_shift ^ crc_run);
               if (rx_stage == ST_LENGTH) begin
                  len_nib = rx_shift[3:0] & LEN_MASK;
                  if (len_nib > MAX_PAYLOAD) begin
                     drop_frame();
                     r.frame_abort = 1'b1;
                  end else begin
                     close_field(rx_shift, r);
                     left_cnt = len_nib;
                     rx_stage = (len_nib != 4'd0) ? ST_PAYLOAD : ST_CRC;
                  end
               end else if (rx_stage == ST_PAYLOAD) begin
                  if (pos_cnt == DEST_ID_POS) dest_byte = rx_shift;
                  close_field(rx_shift, r);
                  if (left_cnt <= 4'd1) begin
                     left_cnt = 4'd0;
                     rx_stage = ST_CRC;
                  end else begin
                     left_cnt = left_cnt - 4'd1;
                  end
               end else begin
                  close_field(rx_shift, r);
                  run_ones = 4'd0;
                  run_zeros = 4'd0;
                  rx_stage = ST_MARK;
               end
            end
         end
         ST_MARK: begin
            if (t.rx_bit) rx_shift |= rx_mask;
            rx_mask >>= 1;
            if (rx_mask == 8'h00) begin
               r.crc_ok = (crc_run == 8'h00);
               r.ack_request = (rx_shift == END_MARK) && id_listed();
               close_field(rx_shift, r);
               rx_stage = ST_RESPONSE;
            end
         end
         ST_RESPONSE: begin
            if (t.rx_bit) rx_shift |= rx_mask;
            rx_mask >>= 1;
            if (rx_mask == 8'h00 || (rx_mask[4:0] & RESP_DONE_MASK) != 5'd0) begin
               close_field(rx_shift, r);
               r.frame_done = 1'b1;
               r.crc_ok = (crc_run == 8'h00);
               drop_frame();
            end
         end
         default: drop_frame();
      endcase
   endtask

   // ---------------------------------------------------------------- generator

   task automatic push_tick(input logic rx, input logic busy);
      req_type t;
      t.rx_bit = rx;
      t.tx_busy = busy;
      pending_ticks.push_back(t);
      pushed_total++;
   endtask

   // one frame bit, sometimes preceded by a tick the own transmitter owns
   task automatic push_frame_bit(input logic b);
      if (cut_budget == 0) return;
      if (cut_budget > 0) cut_budget--;
      if ($urandom_range(0, 29) == 0) push_tick(1'($urandom_range(0, 1)), 1'b1);
      push_tick(b, 1'b0);
   endtask

   // msb first with a complement bit after five equal bits
   task automatic push_coded_byte(input logic [7:0] v, input bit stuff_on, input bit last);
      for (int i = 7; i >= 0; i--) begin
         push_frame_bit(v[i]);
         if (v[i] == enc_level && enc_run != 0) begin
            enc_run++;
         end else begin
            enc_level = v[i];
            enc_run = 1;
         end
         // no stuff bit after the crc byte: the receiver stops counting there
         if (stuff_on && enc_run == 5 && !(last && i == 0)) begin
            push_frame_bit(!v[i]);
            enc_level = !v[i];
            enc_run = 1;
         end
      end
   endtask

   task automatic send_frame(input frame_kind_type kind, input int len, input int pattern);
      logic [7:0] body[$];
      logic [7:0] acc;
      logic [7:0] v;
      logic [7:0] mark;
      bit         stuff_on;
      stuff_on = (kind != FRAME_NO_STUFF);
      if (kind == FRAME_OVERLEN) len = $urandom_range(MAX_PAYLOAD + 1, 15);
      cut_budget = (kind == FRAME_CUT) ? $urandom_range(1, 20 + 10 * len) : -1;
      v[7:4] = 4'($urandom_range(0, 15));
      v[3:0] = len[3:0];
      body.push_back(v);
      if (kind != FRAME_OVERLEN) begin
         for (int k = 0; k < len; k++) begin
            case (pattern)
               PAT_ZEROS: v = 8'h00;
               PAT_ONES:  v = 8'hff;
               default:   v = 8'($urandom_range(0, 255));
            endcase
            if (k == 0 && $urandom_range(0, 1) == 1) begin
               v = cfg_ids[$urandom_range(0, ID_SLOTS - 1)];
            end
            body.push_back(v);
         end
         acc = 8'h00;
         foreach (body[i]) acc = crc_advance(body[i] ^ acc);
         if (kind == FRAME_BAD_CRC) acc ^= (8'h01 << $urandom_range(0, 7));
         body.push_back(acc);
      end
      push_frame_bit(1'b1);
      push_frame_bit(1'($urandom_range(0, 1)));
      enc_run = 0;
      enc_level = 1'b0;
      foreach (body[i]) push_coded_byte(body[i], stuff_on, i == body.size() - 1);
      if (kind != FRAME_OVERLEN) begin
         mark = END_MARK;
         if (kind == FRAME_BAD_MARK) begin
            mark = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 255))
                                               : END_MARK ^ (8'h01 << $urandom_range(0, 7));
         end
         for (int i = 7; i >= 0; i--) push_frame_bit(mark[i]);
         repeat (3) push_frame_bit(1'($urandom_range(0, 1)));
      end
      cut_budget = -1;
      // zeros long enough to bring the receiver back to idle after a broken frame
      if (kind == FRAME_NO_STUFF || kind == FRAME_CUT) repeat (24) push_tick(1'b0, 1'b0);
      repeat ($urandom_range(0, 3)) push_tick(1'b0, 1'b0);
   endtask

   task automatic send_noise();
      repeat ($urandom_range(4, 20)) begin
         push_tick(1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0);
      end
      repeat (24) push_tick(1'b0, 1'b0);
   endtask

   task automatic random_traffic(input int n);
      int target;
      int pick;
      int len;
      int pat;
      target = pushed_total + n;
      while (pushed_total < target) begin
         pick = $urandom_range(0, 99);
         len = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 4) : $urandom_range(0, MAX_PAYLOAD);
         pat = $urandom_range(0, 9);
         pat = (pat == 0) ? PAT_ZEROS : (pat == 1) ? PAT_ONES : PAT_RANDOM;
         if (pick < 60)      send_frame(FRAME_GOOD, len, pat);
         else if (pick < 68) send_frame(FRAME_BAD_CRC, len, pat);
         else if (pick < 75) send_frame(FRAME_BAD_MARK, len, pat);
         else if (pick < 82) send_frame(FRAME_OVERLEN, len, pat);
         else if (pick < 88) send_frame(FRAME_NO_STUFF, len, pat);
         else if (pick < 95) send_frame(FRAME_CUT, len, pat);
         else                send_noise();
      end
   endtask

   // ---------------------------------------------------------------- registers

   task automatic csr_write(input logic [2:0] idx, input logic [7:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      apply_register(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic program_regs(input logic [7:0] poly, input logic [2:0] count,
                               input logic [7:0] id0, input logic [7:0] id1,
                               input logic [7:0] id2, input logic [7:0] id3);
      logic [4:0] junk;
      junk = 5'($urandom_range(0, 31));
      csr_write(CSR_CRC_POLY, poly);
      csr_write(CSR_ACK_ID_COUNT, {junk, count});
      csr_write(CSR_ACK_ID_A, id0);
      csr_write(CSR_ACK_ID_B, id1);
      csr_write(CSR_ACK_ID_C, id2);
      csr_write(CSR_ACK_ID_D, id3);
      // writes to the unused indexes must leave everything alone
      csr_write(($urandom_range(0, 1) == 1) ? CSR_SPARE_HI : CSR_SPARE_LO,
                8'($urandom_range(0, 255)));
      phases_run++;
   endtask

   task automatic wait_drain();
      while (results_seen != pushed_total) @(negedge clock);
      repeat (DRAIN_TAIL) @(negedge clock);
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(negedge clock);

      // all ids enabled, first id zero so a zero-length frame is acknowledged
      program_regs(8'h07, 3'd4, 8'h00, 8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
      // directed frames: idle and busy ticks, length extremes, aborts, bad fields
      push_tick(1'b0, 1'b0);
      push_tick(1'b1, 1'b1);
      push_tick(1'b0, 1'b1);
      push_tick(1'b0, 1'b0);
      send_frame(FRAME_GOOD, 0, PAT_RANDOM);
      send_frame(FRAME_GOOD, MAX_PAYLOAD, PAT_ONES);
      send_frame(FRAME_GOOD, MAX_PAYLOAD, PAT_ZEROS);
      send_frame(FRAME_OVERLEN, 0, PAT_RANDOM);
      send_frame(FRAME_NO_STUFF, 2, PAT_ONES);
      send_frame(FRAME_BAD_CRC, 1, PAT_RANDOM);
      send_frame(FRAME_BAD_MARK, 1, PAT_RANDOM);
      random_traffic(270);
      wait_drain();

      // zero polynomial, nothing acknowledged
      program_regs(8'h00, 3'd0, 8'hff, 8'hff, 8'hff, 8'hff);
      random_traffic(270);
      wait_drain();

      // full polynomial, id count past the number of slots
      program_regs(8'hff, 3'd7, 8'($urandom_range(0, 255)), 8'hff, 8'($urandom_range(0, 255)),
                   8'h00);
      random_traffic(270);
      wait_drain();

      // random setting, no idling on either side
      bursty = 1'b0;
      program_regs(8'($urandom_range(0, 255)), 3'($urandom_range(1, 3)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      random_traffic(270);
      wait_drain();

      if (expected_beats.size() != 0) begin
         $display("%0t: %0d expected result beats never arrived", $time, expected_beats.size());
         errors++;
      end
      $display("run covered %0d bus ticks over %0d register settings", ticks_accepted, phases_run);
      $display("frames closed %0d (crc good %0d), dropped %0d, ack requests %0d",
               frames_closed, crc_good, frames_dropped, acks_seen);
      if (errors == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

   // ---------------------------------------------------------------- req driver

   always @(negedge clock) begin : drive_req
      logic       next_valid;
      logic [7:0] next_data;
      req_type    t;
      next_valid = req_tvalid;
      next_data = req_tdata;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_tvalid || req_beat_taken) begin
         next_valid = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
         end else if (bursty && $urandom_range(0, 11) == 0) begin
            send_gap = $urandom_range(0, 4);
         end else if (pending_ticks.size() != 0) begin
            t = pending_ticks.pop_front();
            next_data = {6'b0, t};
            next_valid = 1'b1;
         end
      end
      req_tvalid <= next_valid;
      req_tdata <= next_data;
   end

   // ---------------------------------------------------------------- rsp ready

   always @(negedge clock) begin : drive_rsp_ready
      logic ready_next;
      ready_next = 1'b1;
      if (reset) begin
         ready_next = 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         ready_next = 1'b0;
      end else if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
         // long hold-off so the block backs up into its input
         long_hold_done = 1'b1;
         hold_left = LONG_HOLD_CYCLES - 1;
         ready_next = 1'b0;
      end else if (sink_gap > 0) begin
         sink_gap--;
         ready_next = 1'b0;
      end else if (bursty && $urandom_range(0, 7) == 0) begin
         sink_gap = $urandom_range(0, 4);
         ready_next = 1'b0;
      end
      rsp_tready <= ready_next;
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin : observe
      req_type t;
      rsp_type want;
      rsp_type got;
      req_beat_taken = req_tvalid && req_tready;
      if (req_beat_taken) begin
         t = req_type'(req_tdata[1:0]);
         predict_tick(t, want);
         expected_beats.push_back(want);
         ticks_accepted++;
      end
      if (rsp_tvalid && rsp_tready) begin
         got.byte_valid = rsp_tdata[0];
         got.byte_value = rsp_tdata[8:1];
         got.byte_position = rsp_tdata[13:9];
         got.crc_ok = rsp_tdata[14];
         got.ack_request = rsp_tdata[15];
         got.frame_abort = rsp_tdata[16];
         got.frame_done = rsp_tlast;
         if (expected_beats.size() == 0) begin
            $display("%0t: result beat with nothing expected, actual %s", $time, rsp_text(got));
            errors++;
         end else begin
            want = expected_beats.pop_front();
            if (got !== want) begin
               $display("%0t: result beat %0d mismatch, expected %s, actual %s",
                        $time, results_seen, rsp_text(want), rsp_text(got));
               errors++;
            end
            if (want.frame_done) frames_closed++;
            if (want.frame_done && want.crc_ok) crc_good++;
            if (want.frame_abort) frames_dropped++;
            if (want.ack_request) acks_seen++;
            results_seen++;
         end
      end
      // watchdog on cycles with no beat on any channel
      if (!reset) begin
         if (req_beat_taken || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, pushed_total - results_seen);
            $display("tb_top: FAIL");
            $finish;
         end
      end
   end

endmodule
